[hw/rtl/gamepad_input_conditioner_defines.svh]
// Assertion helpers shared by the RTL
`ifndef GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH
`define GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH

// Concurrent check on clk_i, off while rst_ni is low
`define GIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true
`define GIC_ASSERT_NEVER(label, cond, msg) \
  `GIC_ASSERT(label, !(cond), msg)

`endif

[hw/rtl/gic_pkg.sv]
package gic_pkg;

  // Field widths
  localparam int unsigned PAD_COUNT  = 4;
  localparam int unsigned PAD_W      = 2;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned BTN_W      = 16;
  localparam int unsigned PULL_W     = 8;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned TFLAG_W    = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Right stick deflection per cursor pixel
  localparam int unsigned CURSOR_DIV = 10000;

  // Register reset values
  localparam logic              DZ_EN_RST   = 1'b1;
  localparam logic [DZ_W-1:0]   DZ_RST      = 15'd7849;
  localparam logic [PULL_W-1:0] TRIG_TH_RST = 8'd30;
  localparam logic [COORD_W-1:0] SCR_W_RST  = 16'd1920;
  localparam logic [COORD_W-1:0] SCR_H_RST  = 16'd1080;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DZ_EN   = 3'd0,
    CFG_DZ      = 3'd1,
    CFG_TRIG_TH = 3'd2,
    CFG_SCR_W   = 3'd3,
    CFG_SCR_H   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                dz_en;
    logic [DZ_W-1:0]     dz;
    logic [PULL_W-1:0]   trig_th;
    logic [COORD_W-1:0]  scr_w;
    logic [COORD_W-1:0]  scr_h;
  } cfg_t;

  // Per-controller state entry
  typedef struct packed {
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [BTN_W-1:0]   buttons;
    logic [PULL_W-1:0]  left_pull;
    logic [PULL_W-1:0]  right_pull;
  } pad_state_t;

  typedef struct packed {
    logic [PAD_W-1:0]         pad;
    logic                     connected;
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
    logic [BTN_W-1:0]         buttons;
    logic [PULL_W-1:0]        lp;
    logic [PULL_W-1:0]        rp;
  } sample_t;

  typedef struct packed {
    logic [PAD_W-1:0]         pad_id;
    logic                     link_up;
    logic signed [AXIS_W-1:0] clx;
    logic signed [AXIS_W-1:0] cly;
    logic signed [AXIS_W-1:0] crx;
    logic signed [AXIS_W-1:0] cry;
    logic [COORD_W-1:0]       cur_x;
    logic [COORD_W-1:0]       cur_y;
    logic [BTN_W-1:0]         down;
    logic [BTN_W-1:0]         pressed;
    logic [BTN_W-1:0]         released;
    logic [TFLAG_W-1:0]       tflags;
  } result_t;

  // State write request
  typedef struct packed {
    logic             en;
    logic [PAD_W-1:0] pad;
    pad_state_t       data;
  } state_wr_t;

endpackage

[hw/rtl/gic_cfg_regs.sv]
module gic_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [gic_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gic_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output gic_pkg::cfg_t                    cfg_o
);

  gic_pkg::cfg_t cfg_q, cfg_d;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (gic_pkg::cfg_reg_e'(cfg_index_i))
        gic_pkg::CFG_DZ_EN:   cfg_d.dz_en   = cfg_data_i[0];
        gic_pkg::CFG_DZ:      cfg_d.dz      = cfg_data_i[gic_pkg::DZ_W-1:0];
        gic_pkg::CFG_TRIG_TH: cfg_d.trig_th = cfg_data_i[gic_pkg::PULL_W-1:0];
        gic_pkg::CFG_SCR_W:   cfg_d.scr_w   = cfg_data_i[gic_pkg::COORD_W-1:0];
        gic_pkg::CFG_SCR_H:   cfg_d.scr_h   = cfg_data_i[gic_pkg::COORD_W-1:0];
        default:              cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dz_en   <= gic_pkg::DZ_EN_RST;
      cfg_q.dz      <= gic_pkg::DZ_RST;
      cfg_q.trig_th <= gic_pkg::TRIG_TH_RST;
      cfg_q.scr_w   <= gic_pkg::SCR_W_RST;
      cfg_q.scr_h   <= gic_pkg::SCR_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/gic_state.sv]
module gic_state (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [gic_pkg::PAD_W-1:0]    rd_pad_i,
  output gic_pkg::pad_state_t          rd_state_o,
  input  gic_pkg::state_wr_t           wr_i
);

  gic_pkg::pad_state_t st_q [gic_pkg::PAD_COUNT];

  // Per-controller entries, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gic_pkg::PAD_COUNT; i++) begin
        st_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      st_q[wr_i.pad] <= wr_i.data;
    end
  end

  assign rd_state_o = st_q[rd_pad_i];

endmodule

[hw/rtl/gic_core.sv]
module gic_core (
  input  gic_pkg::sample_t     smp_i,
  input  gic_pkg::cfg_t        cfg_i,
  input  gic_pkg::pad_state_t  cur_i,
  output gic_pkg::result_t     res_o,
  output gic_pkg::pad_state_t  nxt_o,
  output logic                 upd_o
);

  localparam int unsigned AW = gic_pkg::AXIS_W;
  localparam int unsigned CW = gic_pkg::COORD_W;

  // Zero an axis strictly inside the dead zone
  function automatic logic signed [AW-1:0] apply_dz(input logic signed [AW-1:0] v,
                                                     input gic_pkg::cfg_t c);
    logic signed [AW:0] v_ext;
    logic signed [AW:0] dz_ext;
    v_ext  = (AW+1)'(v);
    dz_ext = $signed({2'b00, c.dz});
    if (c.dz_en && (v_ext < dz_ext) && (v_ext > -dz_ext)) begin
      return '0;
    end
    return v;
  endfunction

  // Axis divided by the cursor divisor, truncated toward zero (-3..3)
  function automatic logic signed [2:0] cursor_step(input logic signed [AW-1:0] v);
    logic signed [AW:0] v_ext;
    logic [AW:0]        mag;
    logic [1:0]         q;
    v_ext = (AW+1)'(v);
    mag   = v_ext[AW] ? $unsigned(-v_ext) : $unsigned(v_ext);
    if (mag >= (AW+1)'(3 * gic_pkg::CURSOR_DIV)) begin
      q = 2'd3;
    end else if (mag >= (AW+1)'(2 * gic_pkg::CURSOR_DIV)) begin
      q = 2'd2;
    end else if (mag >= (AW+1)'(gic_pkg::CURSOR_DIV)) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return v_ext[AW] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Clamp a moved coordinate to 0..limit
  function automatic logic [CW-1:0] clamp_coord(input logic signed [CW+1:0] n,
                                                input logic [CW-1:0] limit);
    if (n[CW+1]) begin
      return '0;
    end
    if ($unsigned(n[CW:0]) > {1'b0, limit}) begin
      return limit;
    end
    return n[CW-1:0];
  endfunction

  // Down, pressed, released against a strict threshold
  function automatic logic [2:0] trig_bits(input logic [gic_pkg::PULL_W-1:0] now,
                                           input logic [gic_pkg::PULL_W-1:0] last,
                                           input logic [gic_pkg::PULL_W-1:0] th);
    logic [2:0] f;
    f[0] = now > th;
    f[1] = (now > th) && (last < th);
    f[2] = (now < th) && (last > th);
    return f;
  endfunction

  logic                  in_range;
  logic signed [AW-1:0]  lx, ly, rx, ry;
  logic signed [CW+1:0]  nx, ny;
  logic [CW-1:0]         cx, cy;
  logic [2:0]            lt, rt;

  assign in_range = 32'(smp_i.pad) < gic_pkg::PAD_COUNT;

  assign lx = apply_dz(smp_i.lx, cfg_i);
  assign ly = apply_dz(smp_i.ly, cfg_i);
  assign rx = apply_dz(smp_i.rx, cfg_i);
  assign ry = apply_dz(smp_i.ry, cfg_i);

  // Cursor move: x follows the stick, y is inverted
  assign nx = $signed({2'b00, cur_i.cur_x}) + (CW+2)'(cursor_step(rx));
  assign ny = $signed({2'b00, cur_i.cur_y}) - (CW+2)'(cursor_step(ry));
  assign cx = clamp_coord(nx, cfg_i.scr_w);
  assign cy = clamp_coord(ny, cfg_i.scr_h);

  assign lt = trig_bits(smp_i.lp, cur_i.left_pull, cfg_i.trig_th);
  assign rt = trig_bits(smp_i.rp, cur_i.right_pull, cfg_i.trig_th);

  assign upd_o            = in_range && smp_i.connected;
  assign nxt_o.cur_x      = cx;
  assign nxt_o.cur_y      = cy;
  assign nxt_o.buttons    = smp_i.buttons;
  assign nxt_o.left_pull  = smp_i.lp;
  assign nxt_o.right_pull = smp_i.rp;

  // Result: full when live, cursor only when disconnected, pad id only out of range
  always_comb begin
    res_o        = '0;
    res_o.pad_id = smp_i.pad;
    if (in_range) begin
      res_o.link_up = smp_i.connected;
      if (smp_i.connected) begin
        res_o.clx      = lx;
        res_o.cly      = ly;
        res_o.crx      = rx;
        res_o.cry      = ry;
        res_o.cur_x    = cx;
        res_o.cur_y    = cy;
        res_o.down     = smp_i.buttons;
        res_o.pressed  = ~cur_i.buttons & smp_i.buttons;
        res_o.released = cur_i.buttons & ~smp_i.buttons;
        res_o.tflags   = {rt, lt};
      end else begin
        res_o.cur_x = cur_i.cur_x;
        res_o.cur_y = cur_i.cur_y;
      end
    end
  end

endmodule

[hw/rtl/gamepad_input_conditioner.sv]
// Gamepad input conditioner.
// Input channel (in_valid_i / in_ready_o) takes one poll sample per item:
// controller number, connected flag, four thumb axes, buttons and triggers.
// Output channel (out_valid_o / out_ready_i) gives one result per item:
// dead-zoned axes, the controller's clamped cursor, button masks and
// trigger flags. Configuration writes go on cfg_valid_i / cfg_index_i /
// cfg_data_i; cfg_ready_o is always high. Write only while the block is idle.
// A sample accepted into the input register moves into the output register
// as soon as that one is free or being read, and out_valid_o then rises.
// Throughput is one item per cycle while the receiver does not stall, set
// by the single read-modify-write of the per-controller state between the
// two registers. When the receiver stalls, the result holds and one more
// item waits in the input register; in_ready_o drops only when both are full.
// Reset clears both valid flags, every cursor, the last buttons and trigger
// values of each controller, and loads the register defaults.
`include "gamepad_input_conditioner_defines.svh"

module gamepad_input_conditioner (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gic_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gic_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // sample in
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [gic_pkg::PAD_W-1:0]            pad_index_i,
  input  logic                                 connected_i,
  input  logic signed [gic_pkg::AXIS_W-1:0]    left_x_i,
  input  logic signed [gic_pkg::AXIS_W-1:0]    left_y_i,
  input  logic signed [gic_pkg::AXIS_W-1:0]    right_x_i,
  input  logic signed [gic_pkg::AXIS_W-1:0]    right_y_i,
  input  logic [gic_pkg::BTN_W-1:0]            button_word_i,
  input  logic [gic_pkg::PULL_W-1:0]           left_pull_i,
  input  logic [gic_pkg::PULL_W-1:0]           right_pull_i,
  // result out
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [gic_pkg::PAD_W-1:0]            pad_id_o,
  output logic                                 link_up_o,
  output logic signed [gic_pkg::AXIS_W-1:0]    clean_left_x_o,
  output logic signed [gic_pkg::AXIS_W-1:0]    clean_left_y_o,
  output logic signed [gic_pkg::AXIS_W-1:0]    clean_right_x_o,
  output logic signed [gic_pkg::AXIS_W-1:0]    clean_right_y_o,
  output logic [gic_pkg::COORD_W-1:0]          cursor_x_o,
  output logic [gic_pkg::COORD_W-1:0]          cursor_y_o,
  output logic [gic_pkg::BTN_W-1:0]            buttons_down_o,
  output logic [gic_pkg::BTN_W-1:0]            buttons_pressed_o,
  output logic [gic_pkg::BTN_W-1:0]            buttons_released_o,
  output logic [gic_pkg::TFLAG_W-1:0]          trigger_flags_o
);

  gic_pkg::cfg_t        cfg;
  gic_pkg::sample_t     smp_q;
  gic_pkg::result_t     res, res_q;
  gic_pkg::pad_state_t  cur, nxt;
  gic_pkg::state_wr_t   st_wr;
  logic                 upd;
  logic                 in_vld_q, in_vld_d;
  logic                 out_vld_q, out_vld_d;
  logic                 adv, in_acc;

  assign cfg_ready_o = 1'b1;

  gic_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: item moves to the result register when that one is free
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q.pad       <= pad_index_i;
      smp_q.connected <= connected_i;
      smp_q.lx        <= left_x_i;
      smp_q.ly        <= left_y_i;
      smp_q.rx        <= right_x_i;
      smp_q.ry        <= right_y_i;
      smp_q.buttons   <= button_word_i;
      smp_q.lp        <= left_pull_i;
      smp_q.rp        <= right_pull_i;
    end
  end

  gic_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_pad_i   (smp_q.pad),
    .rd_state_o (cur),
    .wr_i       (st_wr)
  );

  gic_core u_core (
    .smp_i (smp_q),
    .cfg_i (cfg),
    .cur_i (cur),
    .res_o (res),
    .nxt_o (nxt),
    .upd_o (upd)
  );

  // State commits when the item moves on
  assign st_wr.en   = adv && upd;
  assign st_wr.pad  = smp_q.pad;
  assign st_wr.data = nxt;

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign pad_id_o           = res_q.pad_id;
  assign link_up_o          = res_q.link_up;
  assign clean_left_x_o     = res_q.clx;
  assign clean_left_y_o     = res_q.cly;
  assign clean_right_x_o    = res_q.crx;
  assign clean_right_y_o    = res_q.cry;
  assign cursor_x_o         = res_q.cur_x;
  assign cursor_y_o         = res_q.cur_y;
  assign buttons_down_o     = res_q.down;
  assign buttons_pressed_o  = res_q.pressed;
  assign buttons_released_o = res_q.released;
  assign trigger_flags_o    = res_q.tflags;

  // Checks
  `GIC_ASSERT(a_disc_quiet, out_vld_q && !res_q.link_up |-> (res_q.down == '0) && (res_q.tflags == '0), "disconnected result carries flags")
  `GIC_ASSERT_NEVER(a_press_rel, out_vld_q && ((res_q.pressed & res_q.released) != '0), "button both pressed and released")
  `GIC_ASSERT_NEVER(a_press_down, out_vld_q && ((res_q.pressed & ~res_q.down) != '0), "pressed bit not down")
  `GIC_ASSERT_NEVER(a_trig_edge, out_vld_q && ((res_q.tflags[1] && !res_q.tflags[0]) || (res_q.tflags[4] && !res_q.tflags[3]) || (res_q.tflags[2] && res_q.tflags[0]) || (res_q.tflags[5] && res_q.tflags[3])), "trigger edge disagrees with level")
  `GIC_ASSERT(a_no_stall_drop, in_vld_q && out_vld_q && !out_ready_i |=> in_vld_q && out_vld_q, "item dropped under stall")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import gic_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 56;

  typedef struct {
    sample_t s;
    bit      pinned;
    result_t want;
  } poll_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index = CFG_DZ_EN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // sample channel; drv holds the item on the wires
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t drv = '0;
  bit      drv_pinned = 1'b0;
  result_t drv_want = '0;

  // result channel
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [PAD_W-1:0]         pad_id;
  logic                     link_up;
  logic signed [AXIS_W-1:0] clean_lx, clean_ly, clean_rx, clean_ry;
  logic [COORD_W-1:0]       cursor_x, cursor_y;
  logic [BTN_W-1:0]         btn_down, btn_pressed, btn_released;
  logic [TFLAG_W-1:0]       trig_flags;

  // predicted pad results, oldest first
  result_t pad_result_q[$];
  poll_row_t poll_rows[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  idling = 1'b0;

  // predictor copy of the registers
  logic               dz_en_m = DZ_EN_RST;
  logic [DZ_W-1:0]    dz_m    = DZ_RST;
  logic [PULL_W-1:0]  th_m    = TRIG_TH_RST;
  logic [COORD_W-1:0] scr_w_m = SCR_W_RST;
  logic [COORD_W-1:0] scr_h_m = SCR_H_RST;

  // predictor copy of the per-controller state
  logic [COORD_W-1:0] cur_x_mem [PAD_COUNT] = '{default: '0};
  logic [COORD_W-1:0] cur_y_mem [PAD_COUNT] = '{default: '0};
  logic [BTN_W-1:0]   btn_mem   [PAD_COUNT] = '{default: '0};
  logic [PULL_W-1:0]  lpull_mem [PAD_COUNT] = '{default: '0};
  logic [PULL_W-1:0]  rpull_mem [PAD_COUNT] = '{default: '0};

  // button pattern per pad, so random samples often flip only one bit
  logic [BTN_W-1:0] btn_trail [PAD_COUNT] = '{default: '0};

  gamepad_input_conditioner DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .pad_index_i        (drv.pad),
    .connected_i        (drv.connected),
    .left_x_i           (drv.lx),
    .left_y_i           (drv.ly),
    .right_x_i          (drv.rx),
    .right_y_i          (drv.ry),
    .button_word_i      (drv.buttons),
    .left_pull_i        (drv.lp),
    .right_pull_i       (drv.rp),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .pad_id_o           (pad_id),
    .link_up_o          (link_up),
    .clean_left_x_o     (clean_lx),
    .clean_left_y_o     (clean_ly),
    .clean_right_x_o    (clean_rx),
    .clean_right_y_o    (clean_ry),
    .cursor_x_o         (cursor_x),
    .cursor_y_o         (cursor_y),
    .buttons_down_o     (btn_down),
    .buttons_pressed_o  (btn_pressed),
    .buttons_released_o (btn_released),
    .trigger_flags_o    (trig_flags)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int dead_zone_cut(int v);
    if (dz_en_m && v < int'(dz_m) && v > -int'(dz_m)) return 0;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_to(int v, logic [COORD_W-1:0] lim);
    if (v < 0) return '0;
    if (v > int'(lim)) return lim;
    return v[COORD_W-1:0];
  endfunction

  // {released, pressed, down}; equal to threshold counts as neither side
  function automatic logic [2:0] trig_edges(logic [PULL_W-1:0] now, logic [PULL_W-1:0] last);
    return {now < th_m && last > th_m, now > th_m && last < th_m, now > th_m};
  endfunction

  function automatic result_t condition_sample(sample_t s);
    result_t r;
    int lx, ly, rx, ry, nx, ny;
    logic [BTN_W-1:0] old;
    r = '0;
    r.pad_id = s.pad;
    if (s.pad >= PAD_COUNT) return r;
    r.link_up = s.connected;
    // disconnected: state untouched, only the stored cursor shows
    if (!s.connected) begin
      r.cur_x = cur_x_mem[s.pad];
      r.cur_y = cur_y_mem[s.pad];
      return r;
    end
    lx = dead_zone_cut(int'($signed(s.lx)));
    ly = dead_zone_cut(int'($signed(s.ly)));
    rx = dead_zone_cut(int'($signed(s.rx)));
    ry = dead_zone_cut(int'($signed(s.ry)));
    // cursor moves by the truncated right-stick step, y inverted
    nx = int'(cur_x_mem[s.pad]) + rx / int'(CURSOR_DIV);
    ny = int'(cur_y_mem[s.pad]) - ry / int'(CURSOR_DIV);
    cur_x_mem[s.pad] = clamp_to(nx, scr_w_m);
    cur_y_mem[s.pad] = clamp_to(ny, scr_h_m);
    old = btn_mem[s.pad];
    r.tflags = {trig_edges(s.rp, rpull_mem[s.pad]), trig_edges(s.lp, lpull_mem[s.pad])};
    btn_mem[s.pad]   = s.buttons;
    lpull_mem[s.pad] = s.lp;
    rpull_mem[s.pad] = s.rp;
    r.clx      = lx[AXIS_W-1:0];
    r.cly      = ly[AXIS_W-1:0];
    r.crx      = rx[AXIS_W-1:0];
    r.cry      = ry[AXIS_W-1:0];
    r.cur_x    = cur_x_mem[s.pad];
    r.cur_y    = cur_y_mem[s.pad];
    r.down     = s.buttons;
    r.pressed  = ~old & s.buttons;
    r.released = old & ~s.buttons;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic sample_t mk(int pad, int conn, int lx, int ly, int rx, int ry,
                                 int btn, int lp, int rp);
    sample_t s;
    s.pad       = pad[PAD_W-1:0];
    s.connected = conn[0];
    s.lx        = lx[AXIS_W-1:0];
    s.ly        = ly[AXIS_W-1:0];
    s.rx        = rx[AXIS_W-1:0];
    s.ry        = ry[AXIS_W-1:0];
    s.buttons   = btn[BTN_W-1:0];
    s.lp        = lp[PULL_W-1:0];
    s.rp        = rp[PULL_W-1:0];
    return s;
  endfunction

  function automatic result_t mkr(int pad, int link, int clx, int cly, int crx, int cry,
                                  int cx, int cy, int down, int pr, int rel, int tf);
    result_t r;
    r.pad_id   = pad[PAD_W-1:0];
    r.link_up  = link[0];
    r.clx      = clx[AXIS_W-1:0];
    r.cly      = cly[AXIS_W-1:0];
    r.crx      = crx[AXIS_W-1:0];
    r.cry      = cry[AXIS_W-1:0];
    r.cur_x    = cx[COORD_W-1:0];
    r.cur_y    = cy[COORD_W-1:0];
    r.down     = down[BTN_W-1:0];
    r.pressed  = pr[BTN_W-1:0];
    r.released = rel[BTN_W-1:0];
    r.tflags   = tf[TFLAG_W-1:0];
    return r;
  endfunction

  // axis values clustered on the dead-zone edge and the cursor step edges
  function automatic logic [AXIS_W-1:0] rand_axis();
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = int'($urandom());
      2: v = int'(dz_m) + int'($urandom_range(0, 2)) - 1;
      3: v = int'($urandom_range(1, 3)) * 10000 + int'($urandom_range(0, 2)) - 1;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 20000));
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v[AXIS_W-1:0];
  endfunction

  function automatic logic [PULL_W-1:0] rand_pull();
    int t;
    if ($urandom_range(0, 1)) return PULL_W'($urandom());
    t = int'(th_m) + int'($urandom_range(0, 2)) - 1;
    return t[PULL_W-1:0];
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.pad       = PAD_W'($urandom_range(0, PAD_COUNT - 1));
    s.connected = ($urandom_range(0, 7) != 0);
    s.lx        = rand_axis();
    s.ly        = rand_axis();
    s.rx        = rand_axis();
    s.ry        = rand_axis();
    if ($urandom_range(0, 1)) btn_trail[s.pad] = BTN_W'($urandom());
    else btn_trail[s.pad] ^= BTN_W'(1 << $urandom_range(0, BTN_W - 1));
    s.buttons   = btn_trail[s.pad];
    s.lp        = rand_pull();
    s.rp        = rand_pull();
    return s;
  endfunction

  // ---------------------------------------------------------------- channel tasks

  task automatic send_sample(sample_t s, bit pinned, result_t want);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    drv        <= s;
    drv_pinned <= pinned;
    drv_want   <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DZ_EN:   dz_en_m = val[0];
      CFG_DZ:      dz_m    = val[DZ_W-1:0];
      CFG_TRIG_TH: th_m    = val[PULL_W-1:0];
      CFG_SCR_W:   scr_w_m = val;
      CFG_SCR_H:   scr_h_m = val;
      default: ;
    endcase
  endtask

  // stop sending and wait until every predicted result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pad_result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic log_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------- monitors

  // predict on every accepted item
  always @(posedge clk) begin : accept_mon
    result_t r;
    if (rst_n && in_valid && in_ready) begin
      r = condition_sample(drv);
      if (drv_pinned) r = drv_want;
      pad_result_q.push_back(r);
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_chk
    result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pad_result_q.size() == 0) begin
        log_mismatch("result with no pending item");
      end else begin
        w = pad_result_q.pop_front();
        compare_field("pad_id", 16'(pad_id), 16'(w.pad_id));
        compare_field("link_up", 16'(link_up), 16'(w.link_up));
        compare_field("clean_left_x", clean_lx, w.clx);
        compare_field("clean_left_y", clean_ly, w.cly);
        compare_field("clean_right_x", clean_rx, w.crx);
        compare_field("clean_right_y", clean_ry, w.cry);
        compare_field("cursor_x", cursor_x, w.cur_x);
        compare_field("cursor_y", cursor_y, w.cur_y);
        compare_field("buttons_down", btn_down, w.down);
        compare_field("buttons_pressed", btn_pressed, w.pressed);
        compare_field("buttons_released", btn_released, w.released);
        compare_field("trigger_flags", 16'(trig_flags), 16'(w.tflags));
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin : rcv_stall
    int stall_left;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[gamepad_input_conditioner] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin : stim
    logic               dze;
    logic [DZ_W-1:0]    dz;
    logic [PULL_W-1:0]  th;
    logic [COORD_W-1:0] sw, sh;

    // directed items under reset defaults; fixed results where obvious
    // first sample after reset, disconnected: all zero
    poll_rows.push_back('{mk(0, 0, 32767, -32768, 32767, -32768, 'hFFFF, 255, 255), 1'b1,
                          mkr(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    // axes just inside the dead zone, all buttons and left trigger go down
    poll_rows.push_back('{mk(1, 1, 7848, -7848, 100, -100, 'hFFFF, 255, 0), 1'b1,
                          mkr(1, 1, 0, 0, 0, 0, 0, 0, 'hFFFF, 'hFFFF, 0, 'h03)});
    // full-scale axes: cursor steps by 3, everything released, right pressed
    poll_rows.push_back('{mk(1, 1, -32768, 32767, 32767, -32768, 0, 0, 255), 1'b1,
                          mkr(1, 1, -32768, 32767, 32767, -32768, 3, 3, 0, 0, 'hFFFF, 'h1C)});
    // disconnected keeps the stored cursor
    poll_rows.push_back('{mk(1, 0, 1234, -4321, 32767, 32767, 'h5A5A, 200, 3), 1'b1,
                          mkr(1, 0, 0, 0, 0, 0, 3, 3, 0, 0, 0, 0)});
    // axes exactly on the dead zone pass; triggers at threshold: no flags
    poll_rows.push_back('{mk(2, 1, 7849, -7849, -7849, 7849, 'h8001, 30, 30), 1'b1,
                          mkr(2, 1, 7849, -7849, -7849, 7849, 0, 0, 'h8001, 'h8001, 0, 0)});
    // leaving the threshold value gives a level but no edge
    poll_rows.push_back('{mk(2, 1, 0, 0, 0, 0, 'h0001, 31, 29), 1'b1,
                          mkr(2, 1, 0, 0, 0, 0, 0, 0, 'h0001, 0, 'h8000, 'h01)});
    // cursor step boundaries and clamping at zero
    poll_rows.push_back('{mk(3, 1, 0, 0, 29999, -29999, 'hAAAA, 29, 31), 1'b0, '0});
    poll_rows.push_back('{mk(3, 1, 0, 0, -10000, 10000, 'h5555, 31, 29), 1'b0, '0});
    poll_rows.push_back('{mk(3, 1, 0, 0, -9999, 9999, 'h5555, 31, 29), 1'b0, '0});
    poll_rows.push_back('{mk(3, 1, 0, 0, -32768, 32767, 'h0000, 0, 255), 1'b0, '0});
    poll_rows.push_back('{mk(3, 1, 0, 0, -32768, 32767, 'hFFFF, 255, 0), 1'b0, '0});
    poll_rows.push_back('{mk(0, 1, 32767, 32767, 20000, -20000, 'h0F0F, 30, 255), 1'b0, '0});
    poll_rows.push_back('{mk(0, 1, -32768, -32768, 20000, -20000, 'hF0F0, 0, 30), 1'b0, '0});
    // reconnection: edges against the last connected sample
    poll_rows.push_back('{mk(1, 1, -7848, 7848, -1, 1, 'hFFFF, 255, 255), 1'b1,
                          mkr(1, 1, 0, 0, 0, 0, 3, 3, 'hFFFF, 'hFFFF, 0, 'h0B)});
    poll_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    poll_rows.push_back('{mk(2, 1, 1, -1, 8000, -8000, 'h8000, 255, 255), 1'b0, '0});
    poll_rows.push_back('{mk(2, 1, -2, 2, -8000, 8000, 'h0000, 0, 0), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idling = 1'b1;
    foreach (poll_rows[i]) send_sample(poll_rows[i].s, poll_rows[i].pinned, poll_rows[i].want);
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dze = DZ_EN_RST; dz = DZ_RST; th = TRIG_TH_RST; sw = SCR_W_RST; sh = SCR_H_RST; end
        1: begin dze = 1'b0; dz = DZ_RST; th = TRIG_TH_RST; sw = SCR_W_RST; sh = SCR_H_RST; end
        2: begin dze = 1'b1; dz = '0; th = '0; sw = '0; sh = '0; end
        3: begin dze = 1'b1; dz = '1; th = '1; sw = '1; sh = '1; end
        4: begin
          dze = 1'b1; dz = DZ_W'($urandom()); th = PULL_W'($urandom()); sw = 16'd5; sh = 16'd3;
        end
        5: begin
          dze = 1'($urandom()); dz = DZ_W'($urandom()); th = PULL_W'($urandom());
          sw = COORD_W'($urandom_range(0, 40)); sh = COORD_W'($urandom_range(0, 40));
        end
        6: begin dze = 1'b0; dz = '1; th = 8'd128; sw = 16'd10; sh = '1; end
        default: begin dze = 1'b1; dz = 15'd20000; th = 8'd200; sw = 16'd7; sh = 16'd7; end
      endcase
      write_reg(CFG_DZ_EN, CFG_DATA_W'(dze));
      write_reg(CFG_DZ, CFG_DATA_W'(dz));
      write_reg(CFG_TRIG_TH, CFG_DATA_W'(th));
      write_reg(CFG_SCR_W, sw);
      write_reg(CFG_SCR_H, sh);
      cfg_valid <= 1'b0;

      // no idling on either side in the closing phases
      idling = (p < PHASES - 2);
      repeat (ITEMS_PER_PHASE) send_sample(rand_sample(), 1'b0, '0);
      drain();
    end

    if (mismatches == 0) begin
      $display("[gamepad_input_conditioner] OK");
    end else begin
      $display("[gamepad_input_conditioner] ERROR");
    end
    $finish;
  end

endmodule
